// ----- rtl/bvnp_pkg.sv -----
// Shared types and constants for the boot value number parser.
package bvnp_pkg;

	// Default accumulator width and fixed width of the value result field.
	localparam int VALUE_BITS_DEF = 32;
	localparam int OUT_BITS       = 32;

	// Depth of the token queue and of the result queue.
	localparam int QUEUE_DEPTH = 2;

	// Character codes that the classifier recognizes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_X  = 8'h78;

	// Result kinds.
	localparam logic KIND_NUMBER = 1'b0;
	localparam logic KIND_TEXT   = 1'b1;

	// Classified character handed from the front part to the back part.
	typedef struct packed {
		logic       is_sep;
		logic       is_eq;
		logic       is_minus;
		logic       is_x;
		logic       is_b;
		logic       is_dec;
		logic       is_oct;
		logic       is_hex;
		logic [3:0] digit;
	} token_t;

	// One result transaction.
	typedef struct packed {
		logic                kind;
		logic [OUT_BITS-1:0] value;
	} result_t;

endpackage

// ----- rtl/bvnp_fifo.sv -----
// Small synchronous queue used between the parser parts and on the result side.
module bvnp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	// Status and the head entry.
	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage; written only when a transaction enters.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// The fill count never goes past the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("fifo count exceeds depth");

	// The pointers meet whenever the queue is empty or full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_BITS'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("fifo pointers disagree with count");

	// A push without a pop grows the count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo count did not advance on push");
`endif

endmodule

// ----- rtl/bvnp_front.sv -----
// Front part: classifies each incoming character into a token.
module bvnp_front (
	input  logic [7:0]            ch,
	output bvnp_pkg::token_t      tok
);
	import bvnp_pkg::*;

	logic       dec;
	logic       lo_hex;
	logic       up_hex;

	// Character classes.
	assign dec    = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign lo_hex = (ch >= CH_LO_A) && (ch <= CH_LO_F);
	assign up_hex = (ch >= CH_UP_A) && (ch <= CH_UP_F);

	// Build the token, including the digit value for hex digits.
	always_comb begin
		tok.is_sep   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_COMMA) || (ch == CH_NUL);
		tok.is_eq    = (ch == CH_EQUAL);
		tok.is_minus = (ch == CH_MINUS);
		tok.is_x     = (ch == CH_LO_X);
		tok.is_b     = (ch == CH_LO_B);
		tok.is_dec   = dec;
		tok.is_oct   = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
		tok.is_hex   = dec || lo_hex || up_hex;
		priority if (dec) begin
			tok.digit = 4'(ch - CH_ZERO);
		end else if (lo_hex) begin
			tok.digit = 4'(ch - CH_LO_A + 8'd10);
		end else if (up_hex) begin
			tok.digit = 4'(ch - CH_UP_A + 8'd10);
		end else begin
			tok.digit = '0;
		end
	end

endmodule

// ----- rtl/bvnp_back.sv -----
// Back part: parse state machine that accumulates digits and emits results.
module bvnp_back #(
	parameter int VALUE_BITS = bvnp_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bvnp_pkg::token_t    tok,
	input  logic                tok_valid,
	output logic                tok_pop,
	output bvnp_pkg::result_t   res,
	output logic                res_push,
	input  logic                res_full
);
	import bvnp_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST      = 3'd0,
		PH_AFTER_EQ   = 3'd1,
		PH_AFTER_SIGN = 3'd2,
		PH_AFTER_ZERO = 3'd3,
		PH_DIGITS     = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_BIN = 2'd2,
		RADIX_OCT = 2'd3
	} radix_t;

	phase_t                phase_q, phase_d;
	radix_t                radix_q, radix_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic                  neg_q, neg_d;
	logic                  bad_q, bad_d;
	logic                  go;
	logic                  emit;
	logic                  emit_text;
	logic                  emit_one;
	logic                  digit_ok;
	logic [VALUE_BITS-1:0] acc_step;
	logic [VALUE_BITS-1:0] num;

	// A token is taken when one waits and the result queue has room.
	assign go      = tok_valid && !res_full;
	assign tok_pop = go;

	// Digit check and one multiply-add step by the radix, as shifts and adds.
	always_comb begin
		unique case (radix_q)
			RADIX_HEX: begin
				digit_ok = tok.is_hex;
				acc_step = (acc_q << 4) + VALUE_BITS'(tok.digit);
			end
			RADIX_BIN: begin
				digit_ok = tok.is_hex && (tok.digit < 4'd2);
				acc_step = (acc_q << 1) + VALUE_BITS'(tok.digit);
			end
			RADIX_OCT: begin
				digit_ok = tok.is_hex && (tok.digit < 4'd8);
				acc_step = (acc_q << 3) + VALUE_BITS'(tok.digit);
			end
			default: begin
				digit_ok = tok.is_hex && (tok.digit < 4'd10);
				acc_step = (acc_q << 3) + (acc_q << 1) + VALUE_BITS'(tok.digit);
			end
		endcase
	end

	// Next parse state for the token at the head of the queue.
	always_comb begin
		phase_d   = phase_q;
		radix_d   = radix_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		bad_d     = bad_q;
		emit      = 1'b0;
		emit_text = 1'b0;
		emit_one  = 1'b0;
		unique case (phase_q)
			PH_AFTER_EQ, PH_AFTER_SIGN: begin
				priority if (tok.is_sep) begin
					emit      = 1'b1;
					emit_text = 1'b1;
				end else if (phase_q == PH_AFTER_EQ && tok.is_minus) begin
					neg_d   = 1'b1;
					phase_d = PH_AFTER_SIGN;
				end else if (tok.is_dec) begin
					acc_d   = VALUE_BITS'(tok.digit);
					radix_d = RADIX_DEC;
					phase_d = (tok.digit == 4'd0) ? PH_AFTER_ZERO : PH_DIGITS;
				end else begin
					bad_d   = 1'b1;
					phase_d = PH_DIGITS;
				end
			end
			PH_AFTER_ZERO: begin
				if (tok.is_sep) begin
					emit = 1'b1;
				end else begin
					phase_d = PH_DIGITS;
					priority if (tok.is_x) begin
						radix_d = RADIX_HEX;
					end else if (tok.is_b) begin
						radix_d = RADIX_BIN;
					end else if (tok.is_oct) begin
						radix_d = RADIX_OCT;
						acc_d   = VALUE_BITS'(tok.digit);
					end else begin
						bad_d = 1'b1;
					end
				end
			end
			PH_DIGITS: begin
				if (tok.is_sep) begin
					emit      = 1'b1;
					emit_text = bad_q;
				end else if (!bad_q) begin
					if (digit_ok) begin
						acc_d = acc_step;
					end else begin
						bad_d = 1'b1;
					end
				end
			end
			default: begin
				// Awaiting the first character; unused codes land here too.
				if (tok.is_eq) begin
					phase_d = PH_AFTER_EQ;
				end else begin
					emit     = 1'b1;
					emit_one = 1'b1;
				end
			end
		endcase
		// Every emission starts a fresh value.
		if (emit) begin
			phase_d = PH_FIRST;
			radix_d = RADIX_DEC;
			acc_d   = '0;
			neg_d   = 1'b0;
			bad_d   = 1'b0;
		end
	end

	// Result word: one for a value not opened by '=', else the number with its sign; text carries zero.
	assign num = emit_one ? VALUE_BITS'(1) : (neg_q ? (~acc_q + 1'b1) : acc_q);

	always_comb begin
		res.kind  = emit_text ? KIND_TEXT : KIND_NUMBER;
		res.value = emit_text ? '0 : OUT_BITS'(num);
	end

	assign res_push = go && emit;

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			radix_q <= RADIX_DEC;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			bad_q   <= 1'b0;
		end else if (go) begin
			phase_q <= phase_d;
			radix_q <= radix_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			bad_q   <= bad_d;
		end
	end

`ifndef SYNTHESIS
	// A result is only written when the result queue has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	// After an emission the parser waits for the first character again.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (phase_q == PH_FIRST && acc_q == '0 && !neg_q && !bad_q))
		else $error("parser not cleared after emission");

	// Text results carry a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind == KIND_TEXT) |-> (res.value == '0))
		else $error("text result with nonzero value");

	// The accumulator holds while no token is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(acc_q) && $stable(phase_q))
		else $error("parse state changed without a token");
`endif

endmodule

// ----- rtl/boot_value_number_parser.sv -----
// Top level of the boot option value number parser.
//
//   channel  | handshake         | payload      | direction
//   ---------+-------------------+--------------+----------
//   input    | push / full       | ch[7:0]      | in
//   result   | pop / empty       | kind, value  | out
//
// One character per cycle is sustained while the result queue has room; the parse step is one shift-add by the radix.
// A character's result passes through the token queue and then the result queue before it reaches the result ports.
// Reset clears both queues and returns the parser to awaiting a first character.
// A stalled result side fills the result queue, then the token queue, then raises full.
module boot_value_number_parser #(
	parameter int VALUE_BITS = bvnp_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [7:0]                        ch,
	output logic                              empty,
	input  logic                              pop,
	output logic                              kind,
	output logic signed [bvnp_pkg::OUT_BITS-1:0] value
);
	import bvnp_pkg::*;

	token_t  tok_in;
	token_t  tok_head;
	logic    tok_empty;
	logic    tok_pop;
	result_t res_in;
	result_t res_head;
	logic    res_push;
	logic    res_full;

	// Classify the incoming character.
	bvnp_front u_front (
		.ch  (ch),
		.tok (tok_in)
	);

	// Token queue between the front and back parts.
	bvnp_fifo #(
		.WIDTH ($bits(token_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (tok_in),
		.full   (full),
		.pop    (tok_pop),
		.rdata  (tok_head),
		.empty  (tok_empty)
	);

	// Parse state machine.
	bvnp_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok_head),
		.tok_valid (!tok_empty),
		.tok_pop   (tok_pop),
		.res       (res_in),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// Result queue toward the consumer.
	bvnp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign kind  = res_head.kind;
	assign value = $signed(res_head.value);

endmodule

// ----- tb/bvnp_checker.sv -----
// Checker for the boot value number parser: predicts each parse result and compares it.
module bvnp_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic [7:0]                    ch,
	input  logic                          empty,
	input  logic                          pop,
	input  logic                          kind,
	input  logic [bvnp_pkg::OUT_BITS-1:0] value,
	output int                            mismatches,
	output int                            outstanding,
	output int                            compared
);
	import bvnp_pkg::*;

	typedef enum logic [2:0] {
		AWAIT_FIRST,
		AFTER_EQUAL,
		AFTER_SIGN,
		AFTER_ZERO,
		IN_DIGITS
	} parse_phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_HEX,
		RADIX_BIN,
		RADIX_OCT
	} radix_t;

	// Digit code returned for a character that is no hex digit at all.
	localparam logic [4:0] NO_DIGIT = 5'd31;

	// Predicted parser state.
	parse_phase_t phase_q = AWAIT_FIRST;
	radix_t       radix_q = RADIX_DEC;
	logic [31:0]  acc_q   = '0;
	logic         neg_q   = 1'b0;
	logic         bad_q   = 1'b0;

	// Results predicted but not yet taken from the block, oldest first.
	result_t awaited_results[$];

	function automatic logic is_separator(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_COMMA || c == CH_NUL;
	endfunction

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
		if (c >= CH_LO_A && c <= CH_LO_F) return 5'(c - CH_LO_A + 8'd10);
		if (c >= CH_UP_A && c <= CH_UP_F) return 5'(c - CH_UP_A + 8'd10);
		return NO_DIGIT;
	endfunction

	function automatic logic [4:0] radix_base(input radix_t r);
		case (r)
			RADIX_HEX: return 5'd16;
			RADIX_BIN: return 5'd2;
			RADIX_OCT: return 5'd8;
			default: return 5'd10;
		endcase
	endfunction

	task automatic clear_parse();
		phase_q = AWAIT_FIRST;
		radix_q = RADIX_DEC;
		acc_q = '0;
		neg_q = 1'b0;
		bad_q = 1'b0;
	endtask

	// A finished value is queued as a result and the parser starts over.
	task automatic produce(input logic k, input logic [31:0] v);
		result_t r;
		r.kind = k;
		r.value = v;
		awaited_results.push_back(r);
		clear_parse();
	endtask

	// Advance the predicted parser by one character.
	task automatic parse_char(input logic [7:0] c);
		logic       sep;
		logic [4:0] d;
		sep = is_separator(c);
		d = digit_of(c);
		case (phase_q)
			AFTER_EQUAL, AFTER_SIGN: begin
				if (sep) begin
					produce(KIND_TEXT, '0);
				end else if (phase_q == AFTER_EQUAL && c == CH_MINUS) begin
					neg_q = 1'b1;
					phase_q = AFTER_SIGN;
				end else if (d <= 5'd9) begin
					acc_q = {27'd0, d};
					radix_q = RADIX_DEC;
					phase_q = (c == CH_ZERO) ? AFTER_ZERO : IN_DIGITS;
				end else begin
					bad_q = 1'b1;
					phase_q = IN_DIGITS;
				end
			end
			AFTER_ZERO: begin
				if (sep) begin
					produce(KIND_NUMBER, '0);
				end else begin
					phase_q = IN_DIGITS;
					if (c == CH_LO_X) begin
						radix_q = RADIX_HEX;
					end else if (c == CH_LO_B) begin
						radix_q = RADIX_BIN;
					end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
						radix_q = RADIX_OCT;
						acc_q = {27'd0, d};
					end else begin
						bad_q = 1'b1;
					end
				end
			end
			IN_DIGITS: begin
				if (sep) begin
					if (bad_q) produce(KIND_TEXT, '0);
					else produce(KIND_NUMBER, neg_q ? -acc_q : acc_q);
				end else if (!bad_q) begin
					// Digits beyond the radix spoil the value; the sum wraps at 32 bits.
					if (d >= radix_base(radix_q)) bad_q = 1'b1;
					else acc_q = acc_q * radix_base(radix_q) + {27'd0, d};
				end
			end
			default: begin
				if (c == CH_EQUAL) phase_q = AFTER_EQUAL;
				else produce(KIND_NUMBER, 32'd1);
			end
		endcase
	endtask

	// Compare each taken result with the oldest prediction, then predict from the
	// character taken at the same edge.
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		int      errs;
		if (!arst_n) begin
			clear_parse();
			awaited_results.delete();
			mismatches <= 0;
			outstanding <= 0;
			compared <= 0;
		end else begin
			errs = 0;
			if (pop && !empty) begin
				compared <= compared + 1;
				if (awaited_results.size() == 0) begin
					$error("Unexpected result transaction: kind %0d value %0d",
						kind, $signed(value));
					errs++;
				end else begin
					want = awaited_results.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, kind);
						errs++;
					end
					if (value !== want.value) begin
						$error("value: expected %0d, actual %0d",
							$signed(want.value), $signed(value));
						errs++;
					end
				end
			end
			if (push && !full) parse_char(ch);
			mismatches <= mismatches + errs;
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ----- tb/tb_boot_value_number_parser.sv -----
// Testbench top for the boot value number parser: stimulus, flow control and verdict.
module tb_boot_value_number_parser;
	import bvnp_pkg::*;

	localparam int RX_HOLD_CYCLES  = 60;
	localparam int QUIET_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int CHARS_PER_PHASE = 100;
	localparam int BURST_VALUES    = 12;

	typedef enum int {
		FORM_DEC,
		FORM_HEX,
		FORM_BIN,
		FORM_OCT,
		FORM_ZERO
	} number_form_t;

	logic                       clk    = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push   = 1'b0;
	logic [7:0]                 ch     = 8'h00;
	logic                       pop    = 1'b0;
	logic                       full;
	logic                       empty;
	logic                       kind;
	logic signed [OUT_BITS-1:0] value;

	int mismatches;
	int outstanding;
	int compared;
	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;
	int hold_requests = 0;
	int chars_sent    = 0;
	int quiet_cycles  = 0;

	// Characters waiting to be offered to the block.
	logic [7:0] text_q[$];

	boot_value_number_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.ch     (ch),
		.empty  (empty),
		.pop    (pop),
		.kind   (kind),
		.value  (value)
	);

	bvnp_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.ch          (ch),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.value       (value),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared)
	);

	// Clock with a period of 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] pick_separator();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_COMMA;
			default: return CH_NUL;
		endcase
	endfunction

	// Random digit character valid in the given radix, hex letters in either case.
	function automatic logic [7:0] digit_char(input number_form_t form);
		logic [3:0] v;
		case (form)
			FORM_HEX: v = 4'($urandom_range(0, 15));
			FORM_BIN: v = 4'($urandom_range(0, 1));
			FORM_DEC: v = 4'($urandom_range(0, 9));
			default: v = 4'($urandom_range(0, 7));
		endcase
		if (v < 4'd10) return CH_ZERO + v;
		return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + v - 4'd10;
	endfunction

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	// Offer every queued character in turn, idling between them at the current rate.
	task automatic send_text();
		while (text_q.size() > 0) begin
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				push <= 1'b0;
				@(posedge clk);
			end
			push <= 1'b1;
			ch <= text_q.pop_front();
			@(posedge clk);
			while (full) @(posedge clk);
			chars_sent++;
		end
	endtask

	// Queue one random option value: mostly well-formed numbers, some noise.
	task automatic queue_random_value();
		int           shape;
		int           n_digits;
		int           bad_pos;
		logic         inject;
		logic [7:0]   c;
		number_form_t form;
		string        tricky;
		tricky = "-89XBg";
		shape = $urandom_range(0, 99);
		if (shape < 15) begin
			// A value that does not open with '=' is reported as the number one.
			c = 8'($urandom_range(0, 255));
			if (c == CH_EQUAL) c = CH_MINUS;
			text_q.push_back(c);
		end else if (shape < 30) begin
			// Arbitrary bytes after '=', closed by a separator.
			text_q.push_back(CH_EQUAL);
			repeat ($urandom_range(0, 5)) begin
				c = 8'($urandom_range(0, 255));
				text_q.push_back(c);
			end
			text_q.push_back(pick_separator());
		end else begin
			form = number_form_t'($urandom_range(0, 4));
			text_q.push_back(CH_EQUAL);
			if ($urandom_range(0, 1)) text_q.push_back(CH_MINUS);
			case (form)
				FORM_DEC: begin
					c = CH_ZERO + 8'($urandom_range(1, 9));
					text_q.push_back(c);
				end
				FORM_HEX: begin
					text_q.push_back(CH_ZERO);
					text_q.push_back(CH_LO_X);
				end
				FORM_BIN: begin
					text_q.push_back(CH_ZERO);
					text_q.push_back(CH_LO_B);
				end
				FORM_OCT: begin
					text_q.push_back(CH_ZERO);
					text_q.push_back(digit_char(FORM_OCT));
				end
				default: text_q.push_back(CH_ZERO);
			endcase
			// Long digit runs make the accumulator wrap.
			if (form == FORM_ZERO) n_digits = 0;
			else if ($urandom_range(0, 7) == 0) n_digits = $urandom_range(9, 14);
			else n_digits = $urandom_range(0, 6);
			inject = ($urandom_range(0, 9) == 0);
			bad_pos = $urandom_range(0, n_digits);
			for (int i = 0; i <= n_digits; i++) begin
				if (inject && i == bad_pos) begin
					if ($urandom_range(0, 1)) c = tricky[$urandom_range(0, 5)];
					else c = 8'($urandom_range(0, 255));
					text_q.push_back(c);
				end
				if (i < n_digits) text_q.push_back(digit_char(form));
			end
			text_q.push_back(pick_separator());
		end
	endtask

	// Result side: random stalls, plus a long hold-off whenever one is requested.
	initial begin : result_taker
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// Watchdog: too long without any transaction on either side ends the run.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase_goal;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed values: a bare byte, separators right after '=' and '-', a lone zero,
		// negative hex in mixed case, an empty binary value, 8 after a leading zero
		// and a second minus sign.
		text_q.push_back(8'hFF);
		add_str("=,");
		add_str("=-");
		text_q.push_back(CH_NUL);
		add_str("=0\t");
		add_str("=-0xF ");
		add_str("=0b,");
		add_str("=08 ");
		add_str("=--,");
		send_text();

		phase_goal = chars_sent;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 62;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 62;
				end
				default: begin
					tx_idle_pct = 32;
					rx_stall_pct = 32;
				end
			endcase
			if (ph == 0) begin
				// Hold the result side off while a burst of one-character values
				// fills the block and pushes back on the input.
				hold_requests++;
				repeat (BURST_VALUES) begin
					text_q.push_back(8'h01 + 8'($urandom_range(0, 59)));
				end
				send_text();
			end
			phase_goal += CHARS_PER_PHASE;
			while (chars_sent < phase_goal) begin
				queue_random_value();
				send_text();
			end
			// Stop sending until every predicted result has been taken.
			push <= 1'b0;
			@(posedge clk);
			while (outstanding != 0) @(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d characters over four flow-control phases and a long hold-off.",
			chars_sent);
		$display("%0d result transactions were compared with the predicted parse.", compared);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
